FILE: hw/rtl/c_subset_tokenizer_assert.svh
// ---------------------------------------------------------------------------
// Tokenizer assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef C_SUBSET_TOKENIZER_ASSERT_SVH
`define C_SUBSET_TOKENIZER_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define CTZ_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("tokenizer invariant violated");

// When the antecedent holds, the consequent holds at the next clock edge.
`define CTZ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tokenizer sequencing violated");

`endif

FILE: hw/rtl/ctz_pkg.sv
// ---------------------------------------------------------------------------
// ctz_pkg
// Types and constants shared by the tokenizer modules.
// ---------------------------------------------------------------------------
`default_nettype none

package ctz_pkg;

    localparam int MAX_SYMBOL_LEN = 32;
    localparam int SYM_CNT_W      = $clog2(MAX_SYMBOL_LEN + 1);
    localparam int KW_BUF_DEPTH   = 6;

    // Result queue: two slots per transaction plus two spare.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Token kinds.
    localparam logic [4:0] K_LT     = 5'd14;
    localparam logic [4:0] K_BOR    = 5'd16;
    localparam logic [4:0] K_ASSIGN = 5'd20;
    localparam logic [4:0] K_SYMBOL = 5'd21;
    localparam logic [4:0] K_NUMBER = 5'd22;
    localparam logic [4:0] K_INT    = 5'd23;
    localparam logic [4:0] K_CHAR   = 5'd24;
    localparam logic [4:0] K_IF     = 5'd25;
    localparam logic [4:0] K_ELSE   = 5'd26;
    localparam logic [4:0] K_WHILE  = 5'd27;
    localparam logic [4:0] K_NEQ    = 5'd28;
    localparam logic [4:0] K_RETURN = 5'd29;
    localparam logic [4:0] K_END    = 5'd30;
    localparam logic [4:0] K_ERROR  = 5'd31;

    // Error codes.
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_BAR        = 2'd1;
    localparam logic [1:0] ERR_BANG       = 2'd2;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd3;

    typedef struct packed {
        logic [7:0] byte_req;
        logic       end_of_input;
    } ctz_in_t;

    typedef struct packed {
        logic [4:0]         token_kind;
        logic [1:0]         error_code;
        logic signed [31:0] number_value;
        logic [5:0]         symbol_length;
        logic [15:0]        line_number;
        logic [15:0]        column_number;
        logic               last;
    } ctz_result_t;

    typedef struct packed {
        logic [1:0]  count;
        ctz_result_t first;
        ctz_result_t second;
    } ctz_push_t;

    typedef struct packed {
        logic                  room;
        logic [FIFO_CNT_W-1:0] count;
    } ctz_fifo_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ctz_lexer.sv
// ---------------------------------------------------------------------------
// ctz_lexer
// Lexer state and the single-pass next-state and token logic.
// ---------------------------------------------------------------------------
`default_nettype none

module ctz_lexer import ctz_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      step,
    input  wire ctz_in_t   in_data,
    output ctz_push_t      push
);

    typedef enum logic [2:0] {
        MODE_IDLE, MODE_NUM, MODE_SYM, MODE_LT, MODE_BAR, MODE_BANG, MODE_ERR
    } mode_t;

    typedef struct packed {
        logic       hit;
        logic [4:0] idx;
    } punct_t;

    function automatic punct_t punct_lookup(input logic [7:0] b);
        punct_t p;
        p.hit = 1'b1;
        case (b)
            "(": p.idx = 5'd0;
            ")": p.idx = 5'd1;
            "{": p.idx = 5'd2;
            "}": p.idx = 5'd3;
            "[": p.idx = 5'd4;
            "]": p.idx = 5'd5;
            ";": p.idx = 5'd6;
            ",": p.idx = 5'd7;
            "+": p.idx = 5'd8;
            "-": p.idx = 5'd9;
            "/": p.idx = 5'd10;
            "*": p.idx = 5'd11;
            "%": p.idx = 5'd12;
            ">": p.idx = 5'd13;
            "<": p.idx = 5'd14;
            "=": p.idx = 5'd15;
            "|": p.idx = 5'd16;
            "&": p.idx = 5'd17;
            "^": p.idx = 5'd18;
            "~": p.idx = 5'd19;
            default: begin
                p.hit = 1'b0;
                p.idx = 5'd0;
            end
        endcase
        return p;
    endfunction

    function automatic ctz_result_t make_result(input logic [4:0] kind,
                                                input logic [1:0] err,
                                                input logic [31:0] num,
                                                input logic [5:0] len,
                                                input logic [15:0] line,
                                                input logic [15:0] col);
        ctz_result_t r;
        r.token_kind    = kind;
        r.error_code    = err;
        r.number_value  = num;
        r.symbol_length = len;
        r.line_number   = line;
        r.column_number = col;
        r.last          = 1'b0;
        return r;
    endfunction

    mode_t                mode_reg, mode_next;
    logic [31:0]          acc_reg, acc_next;
    logic [7:0]           kw_buf_reg [KW_BUF_DEPTH];
    logic [7:0]           kw_buf_next [KW_BUF_DEPTH];
    logic [SYM_CNT_W-1:0] sym_cnt_reg, sym_cnt_next;
    logic [15:0]          line_reg, line_next;
    logic [15:0]          col_reg, col_next;
    logic [1:0]           err_held_reg, err_held_next;

    logic [7:0]  b;
    logic        b_ws, b_digit, b_alpha, b_end_sym;
    punct_t      b_punct;
    logic [31:0] b_val;
    logic [15:0] line_upd, col_upd;

    // Outcome of a byte that arrives with no token pending.
    mode_t       idle_mode;
    logic        idle_emit;
    ctz_result_t idle_res;

    logic        kw_hit;
    logic [4:0]  kw_kind;
    ctz_result_t sym_res;

    logic        has_a, has_b;
    ctz_result_t res_a, res_b;

    assign b        = in_data.byte_req;
    assign b_ws     = (b == " ") || (b >= 8'd9 && b <= 8'd13);
    assign b_digit  = (b >= "0") && (b <= "9");
    assign b_alpha  = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    assign b_punct  = punct_lookup(b);
    assign b_end_sym = b_ws || (b == 8'd0) || b_punct.hit;
    assign b_val    = {28'd0, 4'(b - "0")};

    always_comb begin
        if (b == 8'd10) begin
            col_upd  = 16'd1;
            line_upd = (line_reg != 16'hFFFF) ? line_reg + 16'd1 : line_reg;
        end else begin
            col_upd  = (col_reg != 16'hFFFF) ? col_reg + 16'd1 : col_reg;
            line_upd = line_reg;
        end
    end

    always_comb begin
        idle_mode = MODE_IDLE;
        idle_emit = 1'b0;
        idle_res  = make_result(b_punct.idx, ERR_NONE, 32'd0, 6'd0, line_upd, col_upd);
        if (b_ws) begin
            idle_mode = MODE_IDLE;
        end else if (b_punct.hit) begin
            if (b_punct.idx == K_LT) begin
                idle_mode = MODE_LT;
            end else if (b_punct.idx == K_BOR) begin
                idle_mode = MODE_BAR;
            end else begin
                idle_emit = 1'b1;
            end
        end else if (b_digit) begin
            idle_mode = MODE_NUM;
        end else if (b_alpha) begin
            idle_mode = MODE_SYM;
        end else if (b == "!") begin
            idle_mode = MODE_BANG;
        end else begin
            idle_mode = MODE_ERR;
            idle_emit = 1'b1;
            idle_res  = make_result(K_ERROR, ERR_UNEXPECTED, 32'd0, 6'd0,
                                    line_upd, col_upd);
        end
    end

    // Keyword match: the count pins how many buffer entries were written.
    always_comb begin
        kw_hit  = 1'b1;
        kw_kind = K_SYMBOL;
        if (sym_cnt_reg == SYM_CNT_W'(3) && kw_buf_reg[0] == "i" && kw_buf_reg[1] == "n"
                && kw_buf_reg[2] == "t") begin
            kw_kind = K_INT;
        end else if (sym_cnt_reg == SYM_CNT_W'(4) && kw_buf_reg[0] == "c"
                && kw_buf_reg[1] == "h" && kw_buf_reg[2] == "a" && kw_buf_reg[3] == "r") begin
            kw_kind = K_CHAR;
        end else if (sym_cnt_reg == SYM_CNT_W'(2) && kw_buf_reg[0] == "i"
                && kw_buf_reg[1] == "f") begin
            kw_kind = K_IF;
        end else if (sym_cnt_reg == SYM_CNT_W'(4) && kw_buf_reg[0] == "e"
                && kw_buf_reg[1] == "l" && kw_buf_reg[2] == "s" && kw_buf_reg[3] == "e") begin
            kw_kind = K_ELSE;
        end else if (sym_cnt_reg == SYM_CNT_W'(5) && kw_buf_reg[0] == "w"
                && kw_buf_reg[1] == "h" && kw_buf_reg[2] == "i" && kw_buf_reg[3] == "l"
                && kw_buf_reg[4] == "e") begin
            kw_kind = K_WHILE;
        end else if (sym_cnt_reg == SYM_CNT_W'(6) && kw_buf_reg[0] == "r"
                && kw_buf_reg[1] == "e" && kw_buf_reg[2] == "t" && kw_buf_reg[3] == "u"
                && kw_buf_reg[4] == "r" && kw_buf_reg[5] == "n") begin
            kw_kind = K_RETURN;
        end else begin
            kw_hit = 1'b0;
        end
    end

    always_comb begin
        mode_next     = mode_reg;
        acc_next      = acc_reg;
        kw_buf_next   = kw_buf_reg;
        sym_cnt_next  = sym_cnt_reg;
        line_next     = line_reg;
        col_next      = col_reg;
        err_held_next = err_held_reg;
        has_a = 1'b0;
        has_b = 1'b0;
        res_a = make_result(K_END, ERR_NONE, 32'd0, 6'd0, line_reg, col_reg);
        res_b = idle_res;
        sym_res = make_result(kw_hit ? kw_kind : K_SYMBOL, ERR_NONE, 32'd0,
                              kw_hit ? 6'd0 : 6'(sym_cnt_reg), line_upd, col_upd);

        if (mode_reg == MODE_ERR) begin
            has_a = 1'b1;
            res_a = make_result(K_ERROR, err_held_reg, 32'd0, 6'd0, line_reg, col_reg);
        end else if (in_data.end_of_input) begin
            // Flush the pending token with the position left unchanged.
            sym_res.line_number   = line_reg;
            sym_res.column_number = col_reg;
            res_b = make_result(K_END, ERR_NONE, 32'd0, 6'd0, line_reg, col_reg);
            has_b = 1'b1;
            case (mode_reg)
                MODE_NUM: begin
                    has_a = 1'b1;
                    res_a = make_result(K_NUMBER, ERR_NONE, acc_reg, 6'd0,
                                        line_reg, col_reg);
                end
                MODE_SYM: begin
                    has_a = 1'b1;
                    res_a = sym_res;
                end
                MODE_LT: begin
                    has_a = 1'b1;
                    res_a = make_result(K_LT, ERR_NONE, 32'd0, 6'd0, line_reg, col_reg);
                end
                MODE_BAR: begin
                    has_b = 1'b0;
                    res_b = make_result(K_ERROR, ERR_BAR, 32'd0, 6'd0, line_reg, col_reg);
                    has_a = 1'b1;
                    res_a = res_b;
                end
                MODE_BANG: begin
                    has_b = 1'b0;
                    res_b = make_result(K_ERROR, ERR_BANG, 32'd0, 6'd0, line_reg, col_reg);
                    has_a = 1'b1;
                    res_a = res_b;
                end
                default: begin
                end
            endcase
            if (mode_reg == MODE_BAR) begin
                mode_next     = MODE_ERR;
                err_held_next = ERR_BAR;
            end else if (mode_reg == MODE_BANG) begin
                mode_next     = MODE_ERR;
                err_held_next = ERR_BANG;
            end else begin
                // End token delivered: back to the reset state for a new source.
                mode_next     = MODE_IDLE;
                acc_next      = 32'd0;
                sym_cnt_next  = '0;
                line_next     = 16'd1;
                col_next      = 16'd0;
                err_held_next = ERR_NONE;
            end
        end else begin
            line_next = line_upd;
            col_next  = col_upd;
            case (mode_reg)
                MODE_NUM: begin
                    if (b_digit) begin
                        acc_next = (acc_reg << 3) + (acc_reg << 1) + b_val;
                    end else begin
                        has_a = 1'b1;
                        res_a = make_result(K_NUMBER, ERR_NONE, acc_reg, 6'd0,
                                            line_upd, col_upd);
                        acc_next = 32'd0;
                        has_b = 1'b1;
                    end
                end
                MODE_SYM: begin
                    if (b_end_sym) begin
                        has_a = 1'b1;
                        res_a = sym_res;
                        sym_cnt_next = '0;
                        has_b = 1'b1;
                    end else begin
                        if (sym_cnt_reg < SYM_CNT_W'(KW_BUF_DEPTH)) begin
                            kw_buf_next[3'(sym_cnt_reg)] = b;
                        end
                        if (sym_cnt_reg < SYM_CNT_W'(MAX_SYMBOL_LEN)) begin
                            sym_cnt_next = sym_cnt_reg + SYM_CNT_W'(1);
                        end
                    end
                end
                MODE_LT: begin
                    has_a = 1'b1;
                    if (b == "-") begin
                        res_a = make_result(K_ASSIGN, ERR_NONE, 32'd0, 6'd0,
                                            line_upd, col_upd);
                        mode_next = MODE_IDLE;
                    end else begin
                        res_a = make_result(K_LT, ERR_NONE, 32'd0, 6'd0, line_upd, col_upd);
                        has_b = 1'b1;
                    end
                end
                MODE_BAR: begin
                    has_a = 1'b1;
                    if (b == "|") begin
                        res_a = make_result(K_BOR, ERR_NONE, 32'd0, 6'd0, line_upd, col_upd);
                        mode_next = MODE_IDLE;
                    end else begin
                        res_a = make_result(K_ERROR, ERR_BAR, 32'd0, 6'd0,
                                            line_upd, col_upd);
                        mode_next     = MODE_ERR;
                        err_held_next = ERR_BAR;
                    end
                end
                MODE_BANG: begin
                    has_a = 1'b1;
                    if (b == "=") begin
                        res_a = make_result(K_NEQ, ERR_NONE, 32'd0, 6'd0, line_upd, col_upd);
                        mode_next = MODE_IDLE;
                    end else begin
                        res_a = make_result(K_ERROR, ERR_BANG, 32'd0, 6'd0,
                                            line_upd, col_upd);
                        mode_next     = MODE_ERR;
                        err_held_next = ERR_BANG;
                    end
                end
                default: begin
                    has_b = 1'b1;
                end
            endcase

            // The byte starts afresh: apply the idle outcome.
            if (has_b) begin
                has_b     = idle_emit;
                mode_next = idle_mode;
                if (b_digit) begin
                    acc_next = b_val;
                end
                if (b_alpha) begin
                    kw_buf_next[0] = b;
                    sym_cnt_next   = SYM_CNT_W'(1);
                end
                if (idle_mode == MODE_ERR) begin
                    err_held_next = ERR_UNEXPECTED;
                end
            end
        end
    end

    always_comb begin
        push.first  = res_a;
        push.second = res_b;
        if (has_a && has_b) begin
            push.count       = step ? 2'd2 : 2'd0;
            push.second.last = 1'b1;
        end else if (has_a) begin
            push.count      = step ? 2'd1 : 2'd0;
            push.first.last = 1'b1;
        end else if (has_b) begin
            push.count      = step ? 2'd1 : 2'd0;
            push.first      = res_b;
            push.first.last = 1'b1;
        end else begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_IDLE;
            acc_reg      <= 32'd0;
            sym_cnt_reg  <= '0;
            line_reg     <= 16'd1;
            col_reg      <= 16'd0;
            err_held_reg <= ERR_NONE;
        end else if (step) begin
            mode_reg     <= mode_next;
            acc_reg      <= acc_next;
            sym_cnt_reg  <= sym_cnt_next;
            line_reg     <= line_next;
            col_reg      <= col_next;
            err_held_reg <= err_held_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            kw_buf_reg <= kw_buf_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ctz_fifo.sv
// ---------------------------------------------------------------------------
// ctz_fifo
// Result queue that takes up to two results a cycle and delivers one while m_ready is high.
// ---------------------------------------------------------------------------
`default_nettype none

module ctz_fifo import ctz_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire ctz_push_t   push,
    output ctz_fifo_status_t status,
    output logic             m_valid,
    input  wire logic        m_ready,
    output ctz_result_t      m_data
);

    ctz_result_t           mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  pop;

    assign m_valid = (count_reg != '0);
    assign m_data  = mem[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    // Room for a full pair of results, judged on the registered count.
    assign status.room  = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign status.count = count_reg;

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_reg + FIFO_PTR_W'(1)] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(push.count);
            rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(pop);
            count_reg  <= count_reg + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/c_subset_tokenizer.sv
// Path: a transaction accepted into the input stage is lexed once the result queue has
// room for two tokens; its first token then enters the queue and raises m_valid.
// Throughput: one source byte per cycle while the result queue has room, set by the
// lexer's single-pass state update; a byte that yields two tokens delivers them one at a time.
// Reset: synchronous, active low; clears the lexer to line 1, column 0 and
// empties the input stage and the four-entry result queue.
// ---------------------------------------------------------------------------
// c_subset_tokenizer
// Streaming tokenizer for a small C-like language, one byte per transaction.
// ---------------------------------------------------------------------------
`default_nettype none

module c_subset_tokenizer import ctz_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire ctz_in_t     s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output ctz_result_t      m_data
);

    // The input stage holds one accepted transaction until the lexer takes it.
    // The lexer takes it only when the result queue can absorb two tokens,
    // which is the most a single byte can produce.
    logic             in_valid_reg;
    ctz_in_t          in_data_reg;
    logic             step;
    ctz_push_t        push;
    ctz_fifo_status_t fifo_status;

    assign step    = in_valid_reg && fifo_status.room;
    // A new byte enters when the stage is empty or drains in this same cycle.
    assign s_ready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // Lexer state and token formation for the byte in the input stage.
    ctz_lexer u_lexer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .in_data (in_data_reg),
        .push    (push)
    );

    // Results wait here so that a stalled consumer never blocks the input side
    // until the queue really runs short of room.
    ctz_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .status  (fifo_status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`include "c_subset_tokenizer_assert.svh"

    // The queue never holds more tokens than it has slots.
    `CTZ_ASSERT_ALWAYS(a_fifo_bound, aclk, aresetn, fifo_status.count <= FIFO_CNT_W'(FIFO_DEPTH))
    // A byte blocked by a full queue stays in the input stage.
    `CTZ_ASSERT_NEXT(a_stage_holds, aclk, aresetn, in_valid_reg && !fifo_status.room, in_valid_reg)
    // With an empty queue and nothing lexed, no token can appear.
    `CTZ_ASSERT_NEXT(a_no_phantom, aclk, aresetn, fifo_status.count == '0 && !step, !m_valid)
    // The lexer only pushes when it steps.
    `CTZ_ASSERT_ALWAYS(a_push_on_step, aclk, aresetn, push.count == 2'd0 || step)

endmodule

`default_nettype wire

FILE: tb/tb_c_subset_tokenizer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_c_subset_tokenizer
// Self-checking bench for the streaming tokenizer. Source bytes go in through
// a valid/ready driver and are lexed a second time by a behavioral lexer in
// the bench. Every token that leaves the block is compared, field by field,
// with the oldest token that this lexer predicted.
// ---------------------------------------------------------------------------

module tb_c_subset_tokenizer;
    import ctz_pkg::*;

    // Cycles of silence on both channels before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Settling time after the last predicted token has been seen, before the final check.
    localparam int DRAIN_CYCLES   = 8;
    // The last part of the stimulus runs with both sides always willing.
    localparam int TAIL_ITEMS     = 200;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [2:0] {
        LEX_IDLE,
        LEX_NUMBER,
        LEX_SYMBOL,
        LEX_LESS,
        LEX_BAR,
        LEX_BANG,
        LEX_ERROR
    } lex_mode_e;

    // -----------------------------------------------------------------------
    // Clock, reset and the signals of the block
    // -----------------------------------------------------------------------
    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    ctz_in_t     s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    ctz_result_t m_data;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    c_subset_tokenizer uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // -----------------------------------------------------------------------
    // Bench state
    // -----------------------------------------------------------------------
    ctz_in_t     pending_items[$];    // source bytes not yet offered to the block
    ctz_result_t expected_tokens[$];  // tokens predicted, not yet seen at m_data
    ctz_result_t want_token;

    // The characters whose position in this string is their token kind.
    string punct_chars = "(){}[];,+-/*%><=|&^~";

    // Shadow copy of the lexer's state.
    lex_mode_e   lx_mode   = LEX_IDLE;
    logic [31:0] lx_value  = '0;
    logic [7:0]  lx_prefix [KW_BUF_DEPTH];
    int unsigned lx_len    = 0;
    logic [15:0] lx_line   = 16'd1;
    logic [15:0] lx_col    = '0;
    logic [1:0]  lx_err    = ERR_NONE;

    int src_gap   = 0;
    int sink_gap  = 0;
    int src_rate  = 0;
    int sink_rate = 0;
    logic [7:0] rate_clock = '0;
    int idle_cycles = 0;

    int mismatch_count  = 0;
    int bytes_accepted  = 0;
    int tokens_checked  = 0;
    int sources_closed  = 0;
    int error_tokens    = 0;
    int peak_line       = 0;
    int peak_col        = 0;

    // -----------------------------------------------------------------------
    // Character classes
    // -----------------------------------------------------------------------
    function automatic bit is_space(logic [7:0] b);
        return b == CH_SPACE || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic bit is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    // Kind of a one-character punctuator, or -1. NUL never matches.
    function automatic int punct_code(logic [7:0] b);
        for (int i = 0; i < punct_chars.len(); i++) begin
            if (punct_chars[i] == b) return i;
        end
        return -1;
    endfunction

    // -----------------------------------------------------------------------
    // Behavioral lexer: predicts the tokens of one accepted transaction
    // -----------------------------------------------------------------------
    function automatic void add_token(logic [4:0] kind, logic [1:0] code,
                                      logic [31:0] value, logic [5:0] len);
        ctz_result_t t;
        t.token_kind    = kind;
        t.error_code    = code;
        t.number_value  = value;
        t.symbol_length = len;
        t.line_number   = lx_line;
        t.column_number = lx_col;
        t.last          = 1'b0;
        expected_tokens.push_back(t);
    endfunction

    function automatic void raise_error(logic [1:0] code);
        lx_mode = LEX_ERROR;
        lx_err  = code;
        add_token(K_ERROR, code, '0, '0);
    endfunction

    function automatic void clear_lexer();
        lx_mode  = LEX_IDLE;
        lx_value = '0;
        lx_len   = 0;
        lx_line  = 16'd1;
        lx_col   = '0;
        lx_err   = ERR_NONE;
    endfunction

    // Only the first few characters are kept, which is enough because every
    // keyword is short and the length has to match as well.
    function automatic bit word_is(string kw);
        if (lx_len != kw.len()) return 1'b0;
        for (int i = 0; i < kw.len(); i++) begin
            if (lx_prefix[i] != kw[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void close_word();
        if (word_is("int"))         add_token(K_INT, ERR_NONE, '0, '0);
        else if (word_is("char"))   add_token(K_CHAR, ERR_NONE, '0, '0);
        else if (word_is("if"))     add_token(K_IF, ERR_NONE, '0, '0);
        else if (word_is("else"))   add_token(K_ELSE, ERR_NONE, '0, '0);
        else if (word_is("while"))  add_token(K_WHILE, ERR_NONE, '0, '0);
        else if (word_is("return")) add_token(K_RETURN, ERR_NONE, '0, '0);
        else                        add_token(K_SYMBOL, ERR_NONE, '0, 6'(lx_len));
    endfunction

    // A byte seen with nothing pending: it may start a token, finish a
    // single-character one, be skipped, or be illegal.
    function automatic void start_token(logic [7:0] b);
        int p;
        p = punct_code(b);
        lx_mode = LEX_IDLE;
        if (is_space(b)) return;
        if (p >= 0) begin
            if (p == K_LT)       lx_mode = LEX_LESS;
            else if (p == K_BOR) lx_mode = LEX_BAR;
            else                 add_token(5'(p), ERR_NONE, '0, '0);
        end else if (is_digit(b)) begin
            lx_mode  = LEX_NUMBER;
            lx_value = 32'(b - 8'h30);
        end else if (is_alpha(b)) begin
            lx_mode      = LEX_SYMBOL;
            lx_prefix[0] = b;
            lx_len       = 1;
        end else if (b == "!") begin
            lx_mode = LEX_BANG;
        end else begin
            raise_error(ERR_UNEXPECTED);
        end
    endfunction

    function automatic void predict_tokens(ctz_in_t item);
        int unsigned     start_count;
        ctz_result_t     t;
        logic [7:0]      b;
        start_count = expected_tokens.size();
        b = item.byte_req;

        if (lx_mode == LEX_ERROR) begin
            // Sticky: one error token per transaction, whatever comes in.
            add_token(K_ERROR, lx_err, '0, '0);
        end else if (item.end_of_input) begin
            case (lx_mode)
                LEX_NUMBER: add_token(K_NUMBER, ERR_NONE, lx_value, '0);
                LEX_SYMBOL: close_word();
                LEX_LESS:   add_token(K_LT, ERR_NONE, '0, '0);
                LEX_BAR:    raise_error(ERR_BAR);
                LEX_BANG:   raise_error(ERR_BANG);
                default: ;
            endcase
            // The end token carries the position reached; then a new source starts.
            if (lx_mode != LEX_ERROR) begin
                add_token(K_END, ERR_NONE, '0, '0);
                clear_lexer();
            end
        end else begin
            if (b == CH_LF) begin
                lx_col = 16'd1;
                if (lx_line != 16'hFFFF) lx_line++;
            end else if (lx_col != 16'hFFFF) begin
                lx_col++;
            end

            case (lx_mode)
                LEX_NUMBER: begin
                    if (is_digit(b)) begin
                        lx_value = lx_value * 32'd10 + 32'(b - 8'h30);
                    end else begin
                        add_token(K_NUMBER, ERR_NONE, lx_value, '0);
                        lx_value = '0;
                        start_token(b);
                    end
                end
                LEX_SYMBOL: begin
                    if (is_space(b) || b == CH_NUL || punct_code(b) >= 0) begin
                        close_word();
                        lx_len = 0;
                        start_token(b);
                    end else begin
                        if (lx_len < KW_BUF_DEPTH) lx_prefix[lx_len] = b;
                        if (lx_len < MAX_SYMBOL_LEN) lx_len++;
                    end
                end
                LEX_LESS: begin
                    lx_mode = LEX_IDLE;
                    if (b == "-") begin
                        add_token(K_ASSIGN, ERR_NONE, '0, '0);
                    end else begin
                        add_token(K_LT, ERR_NONE, '0, '0);
                        start_token(b);
                    end
                end
                LEX_BAR: begin
                    if (b == "|") begin
                        lx_mode = LEX_IDLE;
                        add_token(K_BOR, ERR_NONE, '0, '0);
                    end else begin
                        raise_error(ERR_BAR);
                    end
                end
                LEX_BANG: begin
                    if (b == "=") begin
                        lx_mode = LEX_IDLE;
                        add_token(K_NEQ, ERR_NONE, '0, '0);
                    end else begin
                        raise_error(ERR_BANG);
                    end
                end
                default: start_token(b);
            endcase
        end

        // Flag the final token that this transaction produced.
        if (expected_tokens.size() > start_count) begin
            t = expected_tokens.pop_back();
            t.last = 1'b1;
            expected_tokens.push_back(t);
        end
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------
    function automatic void send_byte(logic [7:0] b);
        ctz_in_t t;
        t.byte_req     = b;
        t.end_of_input = 1'b0;
        pending_items.push_back(t);
    endfunction

    function automatic void send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endfunction

    // The byte that travels with the end marker is ignored, so it is random.
    function automatic void send_end();
        ctz_in_t t;
        t.byte_req     = 8'($urandom_range(0, 255));
        t.end_of_input = 1'b1;
        pending_items.push_back(t);
    endfunction

    function automatic logic [7:0] random_letter();
        if ($urandom_range(0, 1) == 0) return 8'("a" + $urandom_range(0, 25));
        return 8'("A" + $urandom_range(0, 25));
    endfunction

    // Any byte that keeps a symbol going: mostly letters and digits, now and
    // then anything that is neither whitespace, a punctuator nor NUL.
    function automatic logic [7:0] random_word_char();
        logic [7:0] b;
        case ($urandom_range(0, 3))
            0:       b = 8'("0" + $urandom_range(0, 9));
            1: begin
                do b = 8'($urandom_range(1, 255));
                while (is_space(b) || punct_code(b) >= 0);
            end
            default: b = random_letter();
        endcase
        return b;
    endfunction

    function automatic void random_whitespace();
        logic [7:0] pick [6] = '{CH_SPACE, 8'h09, CH_LF, 8'h0B, 8'h0C, 8'h0D};
        int n;
        n = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 2);
        for (int i = 0; i < n; i++) send_byte(pick[$urandom_range(0, 5)]);
    endfunction

    // One well-formed source: complete tokens glued together or split by
    // whitespace, closed by the end marker. Adjacent tokens may merge (a
    // number after a symbol joins it), which is still legal input.
    function automatic void random_source();
        string kw [6] = '{"int", "char", "if", "else", "while", "return"};
        string w;
        int    atoms;
        int    n;
        logic [7:0] c;
        atoms = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 25);
        random_whitespace();
        for (int a = 0; a < atoms; a++) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    c = punct_chars[$urandom_range(0, punct_chars.len() - 1)];
                    if (c == "|") send_text("||");
                    else          send_byte(c);
                end
                2: begin
                    // Keywords, and near misses that must stay symbols.
                    w = kw[$urandom_range(0, 5)];
                    case ($urandom_range(0, 3))
                        0:       send_text(w.substr(0, w.len() - 2));
                        1: begin
                            send_text(w);
                            send_byte(random_word_char());
                        end
                        default: send_text(w);
                    endcase
                end
                3, 4: begin
                    n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 40)
                                                    : $urandom_range(1, 8);
                    send_byte(random_letter());
                    for (int i = 1; i < n; i++) send_byte(random_word_char());
                end
                5, 6: begin
                    n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 12)
                                                    : $urandom_range(1, 4);
                    for (int i = 0; i < n; i++) send_byte(8'("0" + $urandom_range(0, 9)));
                end
                7:       send_text("!=");
                8:       send_text("<-");
                default: send_byte("<");
            endcase
            random_whitespace();
        end
        send_end();
    endfunction

    function automatic int pick_rate();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 8;
            default: return 30;
        endcase
    endfunction

    function automatic string token_text(ctz_result_t t);
        return $sformatf("kind=%0d err=%0d num=%0d len=%0d line=%0d col=%0d last=%0d",
                         t.token_kind, t.error_code, t.number_value, t.symbol_length,
                         t.line_number, t.column_number, t.last);
    endfunction

    function automatic void note_failure(string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("MISMATCH: %s", msg);
    endfunction

    // -----------------------------------------------------------------------
    // Idle-rate schedule: each time the 8-bit rate counter wraps, each side draws a new burst rate,
    // so the run alternates between busy stretches and ones without gaps.
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin
        rate_clock <= rate_clock + 8'd1;
        if (rate_clock == 8'd0) begin
            src_rate  <= pick_rate();
            sink_rate <= pick_rate();
        end
    end

    // -----------------------------------------------------------------------
    // Driver: offers pending bytes on the input channel. A transaction is
    // handed to the lexer model at the edge where it is accepted, and the
    // next one (or an idle burst) is set up at that same edge.
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_tokens(s_data);
                bytes_accepted++;
            end
            // Valid may only drop or change once the current transaction is taken.
            if (!s_valid || s_ready) begin
                if (src_gap != 0) begin
                    s_valid <= 1'b0;
                    src_gap <= src_gap - 1;
                end else if (pending_items.size() >= TAIL_ITEMS &&
                             $urandom_range(0, 99) < src_rate) begin
                    s_valid <= 1'b0;
                    src_gap <= $urandom_range(0, 6);
                end else if (pending_items.size() != 0) begin
                    s_data  <= pending_items.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Result side: random back-pressure bursts.
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            sink_gap <= 0;
        end else if (sink_gap != 0) begin
            m_ready  <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else if (pending_items.size() >= TAIL_ITEMS &&
                     $urandom_range(0, 99) < sink_rate) begin
            m_ready  <= 1'b0;
            sink_gap <= $urandom_range(0, 6);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // -----------------------------------------------------------------------
    // Monitor: every accepted token must match the oldest prediction. A
    // token cannot leave in the cycle its byte is accepted, so the driver's
    // push and this pop never race over the same entry.
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tokens_checked++;
            if (m_data.token_kind == K_END)   sources_closed++;
            if (m_data.token_kind == K_ERROR) error_tokens++;
            if (m_data.line_number > peak_line)   peak_line = m_data.line_number;
            if (m_data.column_number > peak_col)  peak_col  = m_data.column_number;
            if (expected_tokens.size() == 0) begin
                note_failure({"token with nothing predicted: ", token_text(m_data)});
            end else begin
                want_token = expected_tokens.pop_front();
                if (m_data.token_kind    !== want_token.token_kind    ||
                    m_data.error_code    !== want_token.error_code    ||
                    m_data.number_value  !== want_token.number_value  ||
                    m_data.symbol_length !== want_token.symbol_length ||
                    m_data.line_number   !== want_token.line_number   ||
                    m_data.column_number !== want_token.column_number ||
                    m_data.last          !== want_token.last) begin
                    note_failure({"expected ", token_text(want_token),
                                  " got ", token_text(m_data)});
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Watchdog: ends the run when neither channel moves for too long.
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d tokens outstanding",
                         WATCHDOG_LIMIT, expected_tokens.size());
                $display("tb_c_subset_tokenizer: done, errors");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus and end of run
    // -----------------------------------------------------------------------
    initial begin
        logic [7:0] b;

        // Directed: a keyword spoiled by a high byte, assign, a number that
        // wraps to zero, bitwise or, a symbol swallowing '!', a number ended
        // by '<', and a '<' flushed by the end marker. Then an empty source.
        send_text("int");
        send_byte(8'hFF);
        send_text("<-4294967296||x!=7<");
        send_end();
        send_end();

        // Random well-formed sources.
        while (pending_items.size() < 960) random_source();

        // Errors stick until reset, so the broken input closes the run. One
        // of the three error kinds is drawn here, then more input shows that
        // the held code keeps coming back.
        send_text("q1 ");
        case ($urandom_range(0, 2))
            0: begin
                send_byte("|");
                if ($urandom_range(0, 3) == 0) begin
                    send_end();
                end else begin
                    do b = 8'($urandom_range(0, 255)); while (b == "|");
                    send_byte(b);
                end
            end
            1: begin
                send_byte("!");
                if ($urandom_range(0, 3) == 0) begin
                    send_end();
                end else begin
                    do b = 8'($urandom_range(0, 255)); while (b == "=");
                    send_byte(b);
                end
            end
            default: begin
                case ($urandom_range(0, 3))
                    0:       send_byte(CH_NUL);
                    1: begin
                        // NUL ends a symbol and then fails on its own.
                        send_text("ab");
                        send_byte(CH_NUL);
                    end
                    2:       send_byte(8'($urandom_range(128, 255)));
                    default: send_byte("@");
                endcase
            end
        endcase
        for (int i = 0; i < 30; i++) begin
            if ($urandom_range(0, 4) == 0) send_end();
            else                           send_byte(8'($urandom_range(0, 255)));
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Sample away from the active edge so the driver's bookkeeping is settled.
        while (pending_items.size() != 0 || s_valid || expected_tokens.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_tokens.size() != 0)
            note_failure($sformatf("%0d predicted tokens never arrived",
                                   expected_tokens.size()));

        $display("covered %0d input transactions and %0d tokens: %0d sources ended, %0d errors",
                 bytes_accepted, tokens_checked, sources_closed, error_tokens);
        $display("sticky error code %0d at the end; highest line %0d, highest column %0d",
                 lx_err, peak_line, peak_col);
        if (mismatch_count == 0) begin
            $display("tb_c_subset_tokenizer: done, clean");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("tb_c_subset_tokenizer: done, errors");
        end
        $finish;
    end

endmodule

FILE: c_subset_tokenizer.f
+incdir+hw/rtl
hw/rtl/ctz_pkg.sv
hw/rtl/ctz_lexer.sv
hw/rtl/ctz_fifo.sv
hw/rtl/c_subset_tokenizer.sv
tb/tb_c_subset_tokenizer.sv
